@@ sv/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_WIDTH_DEF = 16;
  localparam int NUM_W = 34;
  localparam int DEN_W = 32;
  localparam int INT_W = 64;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] a_num;
    logic [15:0]        a_den;
    logic signed [15:0] b_num;
    logic [15:0]        b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    status;
  } out_t;

endpackage

@@ sv/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rau_pkg::INT_W-1:0]  dividend,
  input  logic [rau_pkg::INT_W-1:0]  divisor,
  output logic                       done,
  output logic [rau_pkg::INT_W-1:0]  quotient,
  output logic [rau_pkg::INT_W-1:0]  remainder
);

  localparam int W = rau_pkg::INT_W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;

  assign trial = {remainder, quotient[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(W);
        quotient <= dividend;
        remainder <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          remainder <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          remainder <= {remainder[W-2:0], quotient[W-1]};
          quotient <= {quotient[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/rational_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Reduced rational add/sub/mul/div with Euclidean gcd on a shared divider.
// Mul/div form the product, then reduce it by the gcd of numerator and denominator;
//   add/sub first take the denominator gcd. Each gcd step is one divider pass.
//   A bad operand or divide by zero goes from idle straight to the result state.
// Throughput: one transaction at a time; in_stall is high until the result is taken.
// Reset: synchronous rst returns the sequencer to idle with no result held.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
  parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rau_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rau_pkg::out_t  out_data
);

  localparam int W = rau_pkg::INT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_G1    = 4'd1;
  localparam logic [3:0] S_FA    = 4'd2;
  localparam logic [3:0] S_FB    = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_COMB  = 4'd6;
  localparam logic [3:0] S_G2    = 4'd7;
  localparam logic [3:0] S_RN    = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;
  localparam logic [3:0] S_CHK   = 4'd12;

  logic [3:0]   state, ret;
  logic [1:0]   op;
  logic         sa, sb, neg;
  logic [W-1:0] ma, mb, ad, bd, mag, den, gd, fa, fb, ta, tb, p, q;
  logic         dv_start, dv_done;
  logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
  logic [WORD_WIDTH-1:0]   mul_a, mul_b;
  logic [2*WORD_WIDTH-1:0] mul_w;
  logic [W-1:0]            mul_p;

  logic [WORD_WIDTH-1:0] an_w, bn_w, ad_w, bd_w, an_m, bn_m;

  assign an_w = WORD_WIDTH'($unsigned(64'(signed'(in_data.a_num))));
  assign bn_w = WORD_WIDTH'($unsigned(64'(signed'(in_data.b_num))));
  assign ad_w = WORD_WIDTH'(in_data.a_den);
  assign bd_w = WORD_WIDTH'(in_data.b_den);
  assign an_m = an_w[WORD_WIDTH-1] ? (~an_w + 1'b1) : an_w;
  assign bn_m = bn_w[WORD_WIDTH-1] ? (~bn_w + 1'b1) : bn_w;

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  assign mul_w = mul_a * mul_b;
  assign mul_p = W'(mul_w);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dv_start <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= in_data.func;
            sa <= an_w[WORD_WIDTH-1];
            sb <= bn_w[WORD_WIDTH-1];
            ma <= W'(an_m);
            mb <= W'(bn_m);
            ad <= W'(ad_w);
            bd <= W'(bd_w);
            if (ad_w == '0 || bd_w == '0 ||
                (in_data.func == rau_pkg::FUNC_DIV && bn_m == '0)) begin
              out_data <= '{res_num: '0, res_den: '0, status: 1'b1};
              state <= S_OUT;
            end else if (in_data.func == rau_pkg::FUNC_ADD ||
                         in_data.func == rau_pkg::FUNC_SUB) begin
              p <= W'(ad_w);
              q <= W'(bd_w);
              state <= S_G1;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_G1, S_G2: begin
          if (q == '0) begin
            if (state == S_G1) begin
              gd <= p;
              dv_a <= bd; dv_b <= p; dv_start <= 1'b1;
              state <= S_WAIT; ret <= S_FA;
            end else begin
              gd <= p;
              dv_a <= mag; dv_b <= p; dv_start <= 1'b1;
              state <= S_WAIT; ret <= S_RN;
            end
          end else begin
            dv_a <= p; dv_b <= q; dv_start <= 1'b1;
            ret <= state; state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (dv_done) begin
            unique case (ret)
              S_G1, S_G2: begin
                p <= q; q <= dv_r; state <= ret;
              end
              S_FA: begin
                fa <= dv_q;
                dv_a <= ad; dv_b <= gd; dv_start <= 1'b1;
                ret <= S_FB;
              end
              S_FB: begin
                fb <= dv_q; state <= S_MUL1;
              end
              S_RN: begin
                mag <= dv_q;
                dv_a <= den; dv_b <= gd; dv_start <= 1'b1;
                ret <= S_RD;
              end
              default: begin
                out_data <= '{
                  res_num: rau_pkg::NUM_W'(neg ? (~mag + 1'b1) : mag),
                  res_den: rau_pkg::DEN_W'(dv_q), status: 1'b0};
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MUL1: begin
          ta <= mul_p; state <= S_MUL2;
        end
        S_MUL2: begin
          tb <= mul_p; state <= S_COMB;
        end
        S_COMB: begin
          unique case (op)
            rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
              den <= mul_p;
              if (sa == (sb ^ (op == rau_pkg::FUNC_SUB))) begin
                mag <= ta + tb; neg <= sa;
              end else if (ta >= tb) begin
                mag <= ta - tb; neg <= sa;
              end else begin
                mag <= tb - ta; neg <= ~sa;
              end
            end
            default: begin
              den <= tb; mag <= ta; neg <= sa ^ sb;
            end
          endcase
          state <= S_CHK;
        end
        S_CHK: begin
          if (den == '0) begin
            out_data <= '{res_num: '0, res_den: '0, status: 1'b1};
            state <= S_OUT;
          end else if (mag == '0) begin
            out_data <= '{res_num: '0, res_den: rau_pkg::DEN_W'(1), status: 1'b0};
            state <= S_OUT;
          end else begin
            p <= mag; q <= den; state <= S_G2;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL1: begin
        unique case (op)
          rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
            mul_a = WORD_WIDTH'(fa); mul_b = WORD_WIDTH'(ma);
          end
          rau_pkg::FUNC_MUL: begin
            mul_a = WORD_WIDTH'(ma); mul_b = WORD_WIDTH'(mb);
          end
          default: begin
            mul_a = WORD_WIDTH'(ma); mul_b = WORD_WIDTH'(bd);
          end
        endcase
      end
      S_MUL2: begin
        unique case (op)
          rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
            mul_a = WORD_WIDTH'(fb); mul_b = WORD_WIDTH'(mb);
          end
          rau_pkg::FUNC_MUL: begin
            mul_a = WORD_WIDTH'(ad); mul_b = WORD_WIDTH'(bd);
          end
          default: begin
            mul_a = WORD_WIDTH'(ad); mul_b = WORD_WIDTH'(mb);
          end
        endcase
      end
      S_COMB: begin mul_a = WORD_WIDTH'(fb); mul_b = WORD_WIDTH'(bd); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives fractions and operation codes into the rational arithmetic unit,
// predicts each reduced result and compares it in order with the output.
// ----------------------------------------------------------------------------
module testbench;

  class frac_scoreboard;
    rau_pkg::out_t pending[$];
    int   errors;

    function logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
      logic [63:0] t;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      return p;
    endfunction

    function void note_input(rau_pkg::in_t x);
      logic sa, sb, neg;
      logic [63:0] ma, mb, ad, bd, mag, den, g, gd, fa, fb, ta, tb;
      rau_pkg::out_t r;
      sa = x.a_num[15];
      sb = x.b_num[15];
      ma = sa ? 64'(-x.a_num) & 64'hffff : 64'(x.a_num) & 64'hffff;
      mb = sb ? 64'(-x.b_num) & 64'hffff : 64'(x.b_num) & 64'hffff;
      ad = 64'(x.a_den);
      bd = 64'(x.b_den);
      r = '0;
      if (ad == 0 || bd == 0 || (x.func == rau_pkg::FUNC_DIV && mb == 0)) begin
        r.status = 1'b1;
        pending.push_back(r);
        return;
      end
      if (x.func == rau_pkg::FUNC_ADD || x.func == rau_pkg::FUNC_SUB) begin
        gd = gcd64(ad, bd);
        fa = bd / gd;
        fb = ad / gd;
        ta = fa * ma;
        tb = fb * mb;
        if (x.func == rau_pkg::FUNC_SUB) sb = !sb;
        den = fb * bd;
        if (sa == sb) begin
          mag = ta + tb;
          neg = sa;
        end else if (ta >= tb) begin
          mag = ta - tb;
          neg = sa;
        end else begin
          mag = tb - ta;
          neg = sb;
        end
      end else if (x.func == rau_pkg::FUNC_MUL) begin
        mag = ma * mb;
        den = ad * bd;
        neg = sa != sb;
      end else begin
        mag = ma * bd;
        den = ad * mb;
        neg = sa != sb;
      end
      if (den == 0) begin
        r.status = 1'b1;
      end else if (mag == 0) begin
        r.res_den = rau_pkg::DEN_W'(1);
      end else begin
        g = gcd64(mag, den);
        mag = mag / g;
        den = den / g;
        r.res_num = neg ? rau_pkg::NUM_W'(-mag) : rau_pkg::NUM_W'(mag);
        r.res_den = rau_pkg::DEN_W'(den);
      end
      pending.push_back(r);
    endfunction

    function void check_result(rau_pkg::out_t y);
      rau_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result num=%0d den=%0d st=%0d", $time,
                 y.res_num, y.res_den, y.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (y.res_num !== e.res_num) begin
        $display("%0t res_num exp %0d got %0d", $time, e.res_num, y.res_num);
        errors++;
      end
      if (y.res_den !== e.res_den) begin
        $display("%0t res_den exp %0d got %0d", $time, e.res_den, y.res_den);
        errors++;
      end
      if (y.status !== e.status) begin
        $display("%0t status exp %0d got %0d", $time, e.status, y.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rau_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rau_pkg::out_t out_data;

  frac_scoreboard sb = new();
  bit   quiet = 1'b0;
  bit   hold_rx = 1'b0;
  int   accepted = 0;

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_input(in_data);
      accepted++;
    end
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_den();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'hffff;
      2: return 16'(1 << $urandom_range(0, 15));
      3: return 16'($urandom_range(1, 16));
      4: return 16'd0;
      default: return 16'($urandom_range(1, 16'hffff));
    endcase
  endfunction

  function automatic logic [15:0] pick_num();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // in_valid stays high on return; drain drops it, as does a random pause in the next send
  task automatic send(logic [1:0] f, logic [15:0] an, logic [15:0] ad,
                      logic [15:0] bn, logic [15:0] bd);
    rau_pkg::in_t x;
    int target;
    x.func = f;
    x.a_num = an;
    x.a_den = ad;
    x.b_num = bn;
    x.b_den = bd;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    target = accepted + 1;
    in_data <= x;
    in_valid <= 1'b1;
    @(negedge clk);
    while (accepted < target) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send(rau_pkg::FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send(rau_pkg::FUNC_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send(rau_pkg::FUNC_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send(rau_pkg::FUNC_DIV, 16'h7fff, 16'hffff, 16'h8000, 16'hffff);
    send(rau_pkg::FUNC_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
    send(rau_pkg::FUNC_ADD, 16'd5, 16'd0, 16'd1, 16'd3);
    send(rau_pkg::FUNC_MUL, 16'd5, 16'd3, 16'd1, 16'd0);
    send(rau_pkg::FUNC_ADD, 16'd7, 16'd3, 16'd4, 16'd1);
    send(rau_pkg::FUNC_SUB, 16'h8000, 16'hffff, 16'h7fff, 16'hfffe);
    send(rau_pkg::FUNC_ADD, 16'hffff, 16'd6, 16'h8000, 16'd4);
    send(rau_pkg::FUNC_MUL, 16'd0, 16'd9, 16'hfff0, 16'd5);
    send(rau_pkg::FUNC_DIV, 16'hfff6, 16'd4, 16'hfffb, 16'd8);
    send(rau_pkg::FUNC_SUB, 16'h7fff, 16'hffff, 16'h8000, 16'h8000);
    send(rau_pkg::FUNC_ADD, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    send(rau_pkg::FUNC_DIV, 16'h0000, 16'd3, 16'd1, 16'd1);
    // sender pauses until everything is out
    drain();
    // long receiver hold while the sender keeps offering
    fork
      begin
        hold_rx = 1'b1;
        repeat (12000) @(negedge clk);
        hold_rx = 1'b0;
      end
      repeat (4) send(2'($urandom), pick_num(), pick_den(), pick_num(), pick_den());
    join
    for (int i = 0; i < 600; i++) begin
      if (i == 540) quiet = 1'b1;
      send(2'($urandom), pick_num(), pick_den(), pick_num(), pick_den());
    end
    drain();
    repeat (2000) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end
endmodule
